@@ src/i2cbr_pkg.sv @@
// Package for the I2C bus health and recovery block: types, codes, reset values.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package i2cbr_pkg;

    // Register field widths
    localparam int HPT_W    = 16;
    localparam int MAXP_W   = 4;
    localparam int THR_W    = 8;
    localparam int HOLD_W   = 24;
    localparam int CFG_W    = 24;
    localparam int CFG_IDX_W = 2;

    localparam int HOLDOFF_WIDTH_DEF = 24;

    // Register reset values
    localparam logic [HPT_W-1:0]  HPT_RESET  = 16'd5;
    localparam logic [MAXP_W-1:0] MAXP_RESET = 4'd9;
    localparam logic [THR_W-1:0]  THR_RESET  = 8'd3;
    localparam logic [HOLD_W-1:0] HOLD_RESET = 24'd2000000;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSES  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAIL_THR    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF     = 2'd3;

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_OUTCOME = 2'd1,
        CMD_POWERUP = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        OUT_OK        = 2'd0,
        OUT_NOT_READY = 2'd1,
        OUT_FAILED    = 2'd2
    } t_outcome;

    typedef enum logic [1:0] {
        EV_NONE      = 2'd0,
        EV_RECOVERED = 2'd1,
        EV_STUCK     = 2'd2
    } t_event;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_SETTLE     = 3'd1,
        PH_PULSE_LOW  = 3'd2,
        PH_PULSE_HIGH = 3'd3,
        PH_STOP_LOW   = 3'd4,
        PH_STOP_SCL   = 3'd5,
        PH_STOP_SDA   = 3'd6
    } t_phase;

    typedef struct packed {
        logic [HPT_W-1:0]  half_period_ticks;
        logic [MAXP_W-1:0] max_pulses;
        logic [THR_W-1:0]  fail_threshold;
        logic [HOLD_W-1:0] holdoff_ticks;
    } t_cfg;

    typedef struct packed {
        logic [1:0] cmd;
        logic [1:0] outcome;
        logic       sda_level;
    } t_item;

    typedef struct packed {
        logic       scl_release;
        logic       sda_release;
        logic       recovering;
        logic [1:0] event_res;
    } t_res;

    typedef struct packed {
        t_phase            phase;
        logic [HPT_W-1:0]  half_timer;
        logic [MAXP_W-1:0] pulse_count;
        logic [THR_W-1:0]  fail_count;
        logic              bus_ready;
        logic              scl_drive;
        logic              sda_drive;
    } t_state;

    localparam t_state ST_RESET = '{
        phase:       PH_IDLE,
        half_timer:  '0,
        pulse_count: '0,
        fail_count:  '0,
        bus_ready:   1'b0,
        scl_drive:   1'b1,
        sda_drive:   1'b1
    };

endpackage

`default_nettype wire

@@ src/i2cbr_item_if.sv @@
// Input channel of the I2C bus recovery block: valid/ready plus the item fields.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface i2cbr_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [1:0] outcome;
    logic       sda_level;

    modport source (output valid, output cmd, output outcome, output sda_level,
                    input ready);
    modport sink (input valid, input cmd, input outcome, input sda_level,
                  output ready);
endinterface

`default_nettype wire

@@ src/i2cbr_res_if.sv @@
// Result channel of the I2C bus recovery block: valid/ready plus the result fields.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface i2cbr_res_if;
    logic       valid;
    logic       ready;
    logic       scl_release;
    logic       sda_release;
    logic       recovering;
    logic [1:0] event_res;

    modport source (output valid, output scl_release, output sda_release,
                    output recovering, output event_res, input ready);
    modport sink (input valid, input scl_release, input sda_release,
                  input recovering, input event_res, output ready);
endinterface

`default_nettype wire

@@ src/i2cbr_cfg.sv @@
// Configuration register bank of the I2C bus recovery block.
// Depends on i2cbr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2cbr_cfg (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [i2cbr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [i2cbr_pkg::CFG_W-1:0]      i_cfg_data,
    output i2cbr_pkg::t_cfg                       o_cfg
);
    import i2cbr_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_period_ticks <= HPT_RESET;
            r_cfg.max_pulses        <= MAXP_RESET;
            r_cfg.fail_threshold    <= THR_RESET;
            r_cfg.holdoff_ticks     <= HOLD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HALF_PERIOD: r_cfg.half_period_ticks <= i_cfg_data[HPT_W-1:0];
                CFG_MAX_PULSES:  r_cfg.max_pulses        <= i_cfg_data[MAXP_W-1:0];
                CFG_FAIL_THR:    r_cfg.fail_threshold    <= i_cfg_data[THR_W-1:0];
                CFG_HOLDOFF:     r_cfg.holdoff_ticks     <= i_cfg_data[HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ src/i2cbr_step.sv @@
// Per-item update of the recovery sequencer, failure counter and holdoff timer.
// Pure combinational; depends on i2cbr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2cbr_step #(
    parameter int HOLDOFF_WIDTH = i2cbr_pkg::HOLDOFF_WIDTH_DEF
) (
    input  wire i2cbr_pkg::t_item         i_item,
    input  wire i2cbr_pkg::t_state        i_state,
    input  wire logic [HOLDOFF_WIDTH-1:0] i_since,
    input  wire i2cbr_pkg::t_cfg          i_cfg,
    output i2cbr_pkg::t_state         o_state,
    output logic [HOLDOFF_WIDTH-1:0]  o_since,
    output i2cbr_pkg::t_res           o_res
);
    import i2cbr_pkg::*;

    localparam int CMP_W = (HOLDOFF_WIDTH > HOLD_W) ? HOLDOFF_WIDTH : HOLD_W;

    t_state                   n_state;
    logic [HOLDOFF_WIDTH-1:0] n_since;
    t_event                   n_event;
    logic                     sample;
    logic                     holdoff_done;
    logic [HPT_W-1:0]         half_period;
    logic [HPT_W-1:0]         timer_inc;

    assign holdoff_done = CMP_W'(i_since) >= CMP_W'(i_cfg.holdoff_ticks);
    assign half_period  = (i_cfg.half_period_ticks == '0) ? HPT_W'(1)
                                                          : i_cfg.half_period_ticks;
    assign timer_inc    = i_state.half_timer + HPT_W'(1);

    // Next state
    always_comb begin
        n_state = i_state;
        n_since = i_since;
        n_event = EV_NONE;
        sample  = 1'b0;

        case (i_item.cmd)
            CMD_TICK: begin
                if (i_since != {HOLDOFF_WIDTH{1'b1}})
                    n_since = i_since + HOLDOFF_WIDTH'(1);
                if (i_state.phase != PH_IDLE) begin
                    if (timer_inc < half_period && timer_inc != '0) begin
                        n_state.half_timer = timer_inc;
                    end else begin
                        n_state.half_timer = '0;
                        case (i_state.phase)
                            PH_SETTLE: begin
                                sample = 1'b1;
                            end
                            PH_PULSE_LOW: begin
                                n_state.phase     = PH_PULSE_HIGH;
                                n_state.scl_drive = 1'b1;
                            end
                            PH_PULSE_HIGH: begin
                                n_state.pulse_count = i_state.pulse_count + MAXP_W'(1);
                                sample = 1'b1;
                            end
                            PH_STOP_LOW: begin
                                n_state.phase     = PH_STOP_SCL;
                                n_state.scl_drive = 1'b1;
                            end
                            PH_STOP_SCL: begin
                                n_state.phase     = PH_STOP_SDA;
                                n_state.sda_drive = 1'b1;
                            end
                            default: begin
                                n_state.phase     = PH_IDLE;
                                n_state.scl_drive = 1'b1;
                                n_state.sda_drive = 1'b1;
                                n_state.bus_ready = 1'b1;
                                n_event           = EV_RECOVERED;
                            end
                        endcase
                        // SDA sampled after the settle time or after a pulse
                        if (sample) begin
                            if (i_item.sda_level) begin
                                n_state.phase     = PH_STOP_LOW;
                                n_state.scl_drive = 1'b0;
                                n_state.sda_drive = 1'b0;
                            end else if (n_state.pulse_count >= i_cfg.max_pulses) begin
                                n_state.phase     = PH_IDLE;
                                n_state.scl_drive = 1'b1;
                                n_state.sda_drive = 1'b1;
                                n_event           = EV_STUCK;
                            end else begin
                                n_state.phase     = PH_PULSE_LOW;
                                n_state.scl_drive = 1'b0;
                            end
                        end
                    end
                end
            end
            CMD_OUTCOME: begin
                if (i_state.phase == PH_IDLE) begin
                    if (i_item.outcome == OUT_OK) begin
                        n_state.fail_count = '0;
                    end else if (i_item.outcome != OUT_NOT_READY && i_state.bus_ready) begin
                        if (i_state.fail_count != {THR_W{1'b1}})
                            n_state.fail_count = i_state.fail_count + THR_W'(1);
                        if (n_state.fail_count >= i_cfg.fail_threshold && holdoff_done) begin
                            n_since             = '0;
                            n_state.fail_count  = '0;
                            n_state.phase       = PH_SETTLE;
                            n_state.half_timer  = '0;
                            n_state.pulse_count = '0;
                            n_state.scl_drive   = 1'b1;
                            n_state.sda_drive   = 1'b1;
                        end
                    end
                end
            end
            CMD_POWERUP: begin
                if (i_state.phase == PH_IDLE && !i_state.bus_ready) begin
                    n_state.phase       = PH_SETTLE;
                    n_state.half_timer  = '0;
                    n_state.pulse_count = '0;
                    n_state.scl_drive   = 1'b1;
                    n_state.sda_drive   = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Outputs
    always_comb begin
        o_state           = n_state;
        o_since           = n_since;
        o_res.scl_release = n_state.scl_drive;
        o_res.sda_release = n_state.sda_drive;
        o_res.recovering  = (n_state.phase != PH_IDLE);
        o_res.event_res   = n_event;
    end

endmodule

`default_nettype wire

@@ src/i2c_bus_health_recovery.sv @@
// I2C bus health monitor and recovery sequencer (SCL clock-pulse style), top level.
// Needs i2cbr_pkg, i2cbr_item_if, i2cbr_res_if, i2cbr_cfg and i2cbr_step.
//
// Usage:
//   i_item carries one command per item: a time tick (with the sampled SDA
//   level), a transaction outcome report, or a power-up recovery request.
//   o_res returns exactly one result per item: the SCL/SDA open-drain
//   releases, the recovering flag and an event code (recovered / stuck).
//   Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data; the user
//   writes them only while the block is idle, which the block does not enforce.
//   Timing: an item is taken into an input register and its update is
//   written to the result register once that register is free, so a
//   receiver stall can delay it. One item per cycle is sustained while o_res
//   accepts; the only loop is the state registers feeding the update logic.
//   Reset (synchronous, active low) restores register defaults, idles the
//   sequencer with both lines released, bus not ready, counters at zero.
//   If the receiver stalls, the result register holds, the input register
//   still takes one more item, and i_item.ready then drops until o_res moves.
`timescale 1ns / 1ps
`default_nettype none

module i2c_bus_health_recovery #(
    parameter int HOLDOFF_WIDTH = i2cbr_pkg::HOLDOFF_WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [i2cbr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [i2cbr_pkg::CFG_W-1:0]     i_cfg_data,
    i2cbr_item_if.sink                           i_item,
    i2cbr_res_if.source                          o_res
);
    import i2cbr_pkg::*;

    t_cfg                     cfg;
    logic                     r_in_valid;
    t_item                    r_in;
    logic                     r_res_valid;
    t_res                     r_res;
    t_state                   r_state;
    logic [HOLDOFF_WIDTH-1:0] r_since;

    t_state                   n_state;
    logic [HOLDOFF_WIDTH-1:0] n_since;
    t_res                     n_res;
    logic                     advance;

    i2cbr_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    i2cbr_step #(
        .HOLDOFF_WIDTH (HOLDOFF_WIDTH)
    ) u_step (
        .i_item  (r_in),
        .i_state (r_state),
        .i_since (r_since),
        .i_cfg   (cfg),
        .o_state (n_state),
        .o_since (n_since),
        .o_res   (n_res)
    );

    assign advance      = r_in_valid && (!r_res_valid || o_res.ready);
    assign i_item.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_res_valid <= 1'b0;
            r_state     <= ST_RESET;
            r_since     <= '0;
        end else begin
            if (i_item.valid && i_item.ready)
                r_in_valid <= 1'b1;
            else if (advance)
                r_in_valid <= 1'b0;

            if (advance)
                r_res_valid <= 1'b1;
            else if (o_res.ready)
                r_res_valid <= 1'b0;

            if (advance) begin
                r_state <= n_state;
                r_since <= n_since;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in.cmd       <= i_item.cmd;
            r_in.outcome   <= i_item.outcome;
            r_in.sda_level <= i_item.sda_level;
        end
        if (advance)
            r_res <= n_res;
    end

    assign o_res.valid       = r_res_valid;
    assign o_res.scl_release = r_res.scl_release;
    assign o_res.sda_release = r_res.sda_release;
    assign o_res.recovering  = r_res.recovering;
    assign o_res.event_res   = r_res.event_res;

`ifndef SYNTHESIS
    // Lines are never driven low while the sequencer is idle
    a_idle_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == PH_IDLE |-> (r_state.scl_drive && r_state.sda_drive))
        else $error("bus line driven low while idle");

    // A recovered or stuck event always ends the sequence
    a_event_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_res.event_res != EV_NONE) |-> !r_res.recovering)
        else $error("event reported while still recovering");

    // Any recovery starts with the failure count cleared
    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase != PH_IDLE && $past(r_state.phase) == PH_IDLE)
        |-> r_state.fail_count == '0)
        else $error("recovery started with failures still counted");
`endif

endmodule

`default_nettype wire
